// ===== src/tdpt_pkg.sv =====
`default_nettype none
package tdpt_pkg;

    localparam int NUMBER_WIDTH = 32;
    // wide enough for the first divisor whose square passes the number
    localparam int DIV_WIDTH    = (NUMBER_WIDTH + 1) / 2 + 1;
    localparam int SQ_WIDTH     = NUMBER_WIDTH;
    localparam int CNT_WIDTH    = $clog2(NUMBER_WIDTH + 1);

    localparam logic [DIV_WIDTH-1:0] FIRST_DIVISOR = DIV_WIDTH'(2);
    localparam logic [SQ_WIDTH-1:0]  FIRST_SQUARE  = SQ_WIDTH'(4);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                    start;
        logic [NUMBER_WIDTH-1:0] dividend;
        logic [DIV_WIDTH-1:0]    divisor;
    } t_rem_req;

    typedef struct packed {
        logic done;
        logic zero;
    } t_rem_rsp;

    typedef struct packed {
        logic idle;
        logic done;
        logic prime;
    } t_seq_stat;

endpackage
`default_nettype wire

// ===== src/trial_division_prime_test_top.sv =====
`default_nettype none
// Trial-division primality test.
//
// Input channel: i_in_valid / o_in_stall carry one word, i_number, a signed
// integer. Output channel: o_out_valid / i_out_stall carry one word per input,
// o_is_prime, set when the number is prime. A word moves on a rising edge with
// valid high and stall low.
//
// Negative numbers, zero and one go from acceptance straight to the done state
// and on to the output register, and the next number is taken once the
// sequencer is back in idle. Otherwise the sequencer tries divisors d = 2, 3
// and upward while d*d <= number, feeding each one to a shared bit-serial
// remainder unit and waiting for its result before it tries the next. A
// large prime near 2^31 needs about 46340 divisors.
// One number is worked on at a time: o_in_stall is high from acceptance until
// the result has been written to the output register.
//
// A finished result waits in the output register while i_out_stall is high;
// the next number is taken meanwhile, and its result is held back until the
// register is free. Synchronous active-low reset empties the block.
module trial_division_prime_test_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic signed [tdpt_pkg::NUMBER_WIDTH-1:0] i_number,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic                                   o_is_prime
);

    tdpt_pkg::t_rem_req  rem_req;
    tdpt_pkg::t_rem_rsp  rem_rsp;
    tdpt_pkg::t_seq_stat seq_stat;

    logic r_out_valid;
    logic r_out_prime;
    logic out_free;
    logic start;

    assign start    = i_in_valid && seq_stat.idle;
    assign out_free = !r_out_valid || !i_out_stall;

    tdpt_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_number   (i_number),
        .i_out_free (out_free),
        .i_rsp      (rem_rsp),
        .o_req      (rem_req),
        .o_stat     (seq_stat)
    );

    tdpt_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rem_req),
        .o_rsp   (rem_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_stat.done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_stat.done) begin
            r_out_prime <= seq_stat.prime;
        end
    end

    assign o_in_stall  = !seq_stat.idle;
    assign o_out_valid = r_out_valid;
    assign o_is_prime  = r_out_prime;

endmodule
`default_nettype wire

// ===== src/tdpt_rem.sv =====
`default_nettype none
module tdpt_rem (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tdpt_pkg::t_rem_req i_req,
    output tdpt_pkg::t_rem_rsp     o_rsp
);

    logic [tdpt_pkg::NUMBER_WIDTH-1:0] r_dvd;
    logic [tdpt_pkg::DIV_WIDTH-1:0]    r_dsr;
    logic [tdpt_pkg::DIV_WIDTH-1:0]    r_rem;
    logic [tdpt_pkg::CNT_WIDTH-1:0]    r_cnt;
    logic                              r_busy;
    logic                              r_done;

    logic [tdpt_pkg::DIV_WIDTH:0]      rem_sh;
    logic [tdpt_pkg::DIV_WIDTH:0]      rem_diff;
    logic [tdpt_pkg::DIV_WIDTH-1:0]    n_rem;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        rem_sh   = {r_rem, r_dvd[tdpt_pkg::NUMBER_WIDTH-1]};
        rem_diff = rem_sh - {1'b0, r_dsr};
        if (rem_sh >= {1'b0, r_dsr}) begin
            n_rem = rem_diff[tdpt_pkg::DIV_WIDTH-1:0];
        end else begin
            n_rem = rem_sh[tdpt_pkg::DIV_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= tdpt_pkg::CNT_WIDTH'(tdpt_pkg::NUMBER_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == tdpt_pkg::CNT_WIDTH'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_dsr <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[tdpt_pkg::NUMBER_WIDTH-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.zero = (r_rem == '0);

endmodule
`default_nettype wire

// ===== src/tdpt_seq.sv =====
`default_nettype none
module tdpt_seq (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [tdpt_pkg::NUMBER_WIDTH-1:0] i_number,
    input  wire logic                          i_out_free,
    input  wire tdpt_pkg::t_rem_rsp            i_rsp,
    output tdpt_pkg::t_rem_req                 o_req,
    output tdpt_pkg::t_seq_stat                o_stat
);

    tdpt_pkg::t_state r_state;
    tdpt_pkg::t_state n_state;

    logic [tdpt_pkg::NUMBER_WIDTH-1:0] r_v;
    logic [tdpt_pkg::DIV_WIDTH-1:0]    r_d;
    logic [tdpt_pkg::SQ_WIDTH-1:0]     r_sq;
    logic                              r_prime;

    logic trivial;
    logic past_root;

    assign trivial   = i_number[tdpt_pkg::NUMBER_WIDTH-1] ||
                       (i_number[tdpt_pkg::NUMBER_WIDTH-1:1] == '0);
    assign past_root = (r_sq > r_v);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tdpt_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = trivial ? tdpt_pkg::S_DONE : tdpt_pkg::S_CHECK;
                end
            end
            tdpt_pkg::S_CHECK: begin
                n_state = past_root ? tdpt_pkg::S_DONE : tdpt_pkg::S_WAIT;
            end
            tdpt_pkg::S_WAIT: begin
                if (i_rsp.done) begin
                    n_state = i_rsp.zero ? tdpt_pkg::S_DONE : tdpt_pkg::S_CHECK;
                end
            end
            tdpt_pkg::S_DONE: begin
                if (i_out_free) begin
                    n_state = tdpt_pkg::S_IDLE;
                end
            end
            default: n_state = tdpt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_req.start    = 1'b0;
        o_req.dividend = r_v;
        o_req.divisor  = r_d;
        o_stat.idle    = 1'b0;
        o_stat.done    = 1'b0;
        o_stat.prime   = r_prime;
        unique case (r_state)
            tdpt_pkg::S_IDLE:  o_stat.idle = 1'b1;
            tdpt_pkg::S_CHECK: o_req.start = !past_root;
            tdpt_pkg::S_WAIT:  o_req.start = 1'b0;
            tdpt_pkg::S_DONE:  o_stat.done = i_out_free;
            default:           o_stat.idle = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tdpt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            tdpt_pkg::S_IDLE: begin
                if (i_start) begin
                    r_v     <= i_number;
                    r_d     <= tdpt_pkg::FIRST_DIVISOR;
                    r_sq    <= tdpt_pkg::FIRST_SQUARE;
                    r_prime <= 1'b0;
                end
            end
            tdpt_pkg::S_CHECK: begin
                if (past_root) begin
                    r_prime <= 1'b1;
                end
            end
            tdpt_pkg::S_WAIT: begin
                // advance to d+1 and (d+1)^2 = d^2 + 2d + 1
                if (i_rsp.done && !i_rsp.zero) begin
                    r_d  <= r_d + 1'b1;
                    r_sq <= r_sq + tdpt_pkg::SQ_WIDTH'({r_d, 1'b1});
                end
            end
            default: begin
            end
        endcase
    end

    a_start_only_in_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req.start |-> (r_state == tdpt_pkg::S_CHECK) && !past_root)
        else $error("remainder started outside check");

    a_check_to_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req.start |=> (r_state == tdpt_pkg::S_WAIT))
        else $error("sequencer did not wait on the remainder unit");

    a_done_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.done |-> i_out_free && (r_state == tdpt_pkg::S_DONE))
        else $error("result issued without a free output slot");

    a_divisor_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tdpt_pkg::S_WAIT) |-> (r_d >= tdpt_pkg::FIRST_DIVISOR))
        else $error("trial divisor below two");

endmodule
`default_nettype wire
